/* rtl/srec_pkg.sv */
// shared types, constants and helpers for the s1 record encoder
package srec_pkg;

    // field widths
    localparam int DATA_W   = 8;
    localparam int CHAR_W   = 7;
    localparam int ADDR_W   = 16;
    localparam int LEN_W    = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // largest data length that keeps the count within one byte
    localparam logic [LEN_W-1:0] REC_LEN_MAX = 8'd252;
    localparam logic [LEN_W-1:0] REC_OVERHEAD = 8'd3;

    // default depth of the request queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_ADDRESS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BYTES   = 2'd2;

    // characters
    localparam logic [CHAR_W-1:0] CHAR_S  = 7'h53;
    localparam logic [CHAR_W-1:0] CHAR_1  = 7'h31;
    localparam logic [CHAR_W-1:0] CHAR_LF = 7'h0A;

    // end of file record, newline included
    localparam int TERM_LEN = 11;
    localparam logic [CHAR_W-1:0] TERM_CHARS [TERM_LEN] = '{
        7'h53, 7'h39, 7'h30, 7'h33, 7'h30, 7'h30,
        7'h30, 7'h30, 7'h46, 7'h43, 7'h0A
    };

    // one classified byte, as handed from front to back
    typedef struct packed {
        logic              header;
        logic [LEN_W-1:0]  count;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              rec_end;
        logic [7:0]        checksum;
        logic              image_end;
    } srec_cmd_t;

    // queue status seen by its neighbors
    typedef struct packed {
        logic not_empty;
        logic not_full;
    } srec_q_stat_t;

    // uppercase ascii hex digit
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
        logic [CHAR_W-1:0] c;
        if (nib < 4'd10) begin
            c = 7'h30 + {3'd0, nib};
        end else begin
            c = 7'h37 + {3'd0, nib};
        end
        return c;
    endfunction

endpackage

/* rtl/srec_front.sv */
// front end: configuration registers, record bookkeeping and byte classification
module srec_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [srec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srec_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    input  logic [srec_pkg::DATA_W-1:0]   in_data,
    output logic                          in_ready,
    input  srec_pkg::srec_q_stat_t        q_stat,
    output logic                          push,
    output srec_pkg::srec_cmd_t           push_cmd
);
    import srec_pkg::*;

    logic [LEN_W-1:0]  record_length_reg;
    logic [ADDR_W-1:0] load_address_reg;
    logic [15:0]       total_bytes_reg;

    logic [15:0]       bytes_done_reg, bytes_done_next;
    logic [LEN_W-1:0]  record_position_reg, record_position_next;
    logic [7:0]        running_sum_reg, running_sum_next;
    logic [ADDR_W-1:0] record_address_reg, record_address_next;

    logic [LEN_W-1:0]  len_eff;
    logic [15:0]       total_eff;
    logic              header;
    logic [ADDR_W-1:0] addr_cur;
    logic [15:0]       remaining;
    logic [LEN_W-1:0]  data_len;
    logic [LEN_W-1:0]  count;
    logic [7:0]        sum_start;
    logic [7:0]        sum_new;
    logic [LEN_W-1:0]  pos_inc;
    logic [16:0]       done_inc;
    logic              image_end;
    logic              rec_end;

    assign in_ready = q_stat.not_full;
    assign push     = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_length_reg <= 8'd16;
            load_address_reg  <= '0;
            total_bytes_reg   <= 16'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RECORD_LENGTH: record_length_reg <= cfg_wr_data[LEN_W-1:0];
                CFG_LOAD_ADDRESS:  load_address_reg  <= cfg_wr_data;
                CFG_TOTAL_BYTES:   total_bytes_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // clamp the registers to legal values
    always_comb begin
        if (record_length_reg == '0) begin
            len_eff = 8'd1;
        end else if (record_length_reg > REC_LEN_MAX) begin
            len_eff = REC_LEN_MAX;
        end else begin
            len_eff = record_length_reg;
        end
        total_eff = (total_bytes_reg == '0) ? 16'd1 : total_bytes_reg;
    end

    // classify the incoming byte
    always_comb begin
        header    = (record_position_reg == '0);
        addr_cur  = (header && bytes_done_reg == '0) ? load_address_reg : record_address_reg;
        remaining = (bytes_done_reg < total_eff) ? (total_eff - bytes_done_reg) : 16'd1;
        data_len  = (remaining < {8'd0, len_eff}) ? remaining[LEN_W-1:0] : len_eff;
        count     = data_len + REC_OVERHEAD;
        sum_start = header ? (count + addr_cur[15:8] + addr_cur[7:0]) : running_sum_reg;
        sum_new   = sum_start + in_data;
        pos_inc   = record_position_reg + 8'd1;
        done_inc  = {1'b0, bytes_done_reg} + 17'd1;
        image_end = (done_inc >= {1'b0, total_eff});
        rec_end   = image_end || (pos_inc >= len_eff);

        push_cmd.header    = header;
        push_cmd.count     = count;
        push_cmd.addr      = addr_cur;
        push_cmd.data      = in_data;
        push_cmd.rec_end   = rec_end;
        push_cmd.checksum  = ~sum_new;
        push_cmd.image_end = image_end;
    end

    // record state update
    always_comb begin
        bytes_done_next      = bytes_done_reg;
        record_position_next = record_position_reg;
        running_sum_next     = running_sum_reg;
        record_address_next  = record_address_reg;
        if (push) begin
            bytes_done_next = image_end ? 16'd0 : done_inc[15:0];
            if (rec_end) begin
                record_position_next = '0;
                running_sum_next     = '0;
                record_address_next  = addr_cur + {8'd0, pos_inc};
            end else begin
                record_position_next = pos_inc;
                running_sum_next     = sum_new;
                record_address_next  = addr_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_done_reg      <= '0;
            record_position_reg <= '0;
            running_sum_reg     <= '0;
            record_address_reg  <= '0;
        end else begin
            bytes_done_reg      <= bytes_done_next;
            record_position_reg <= record_position_next;
            running_sum_reg     <= running_sum_next;
            record_address_reg  <= record_address_next;
        end
    end

endmodule

/* rtl/srec_fifo.sv */
// request queue between the front end and the character sequencer
module srec_fifo #(
    parameter int DEPTH = srec_pkg::QUEUE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  srec_pkg::srec_cmd_t    push_cmd,
    input  logic                   pop,
    output srec_pkg::srec_cmd_t    head_cmd,
    output srec_pkg::srec_q_stat_t q_stat
);
    import srec_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    srec_cmd_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push, do_pop;

    assign q_stat.not_empty = (fill_reg != '0);
    assign q_stat.not_full  = (fill_reg != CNT_FULL);
    assign do_push  = push && q_stat.not_full;
    assign do_pop   = pop && q_stat.not_empty;
    assign head_cmd = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/srec_back.sv */
// back end: walks one request through its characters into the output register
module srec_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  srec_pkg::srec_cmd_t           head_cmd,
    input  srec_pkg::srec_q_stat_t        q_stat,
    output logic                          pop,
    output logic                          out_valid,
    output logic [srec_pkg::CHAR_W-1:0]   out_char,
    output logic                          out_last,
    input  logic                          out_ready
);
    import srec_pkg::*;

    // character positions within one request
    localparam logic [4:0] POS_S       = 5'd0;
    localparam logic [4:0] POS_ONE     = 5'd1;
    localparam logic [4:0] POS_CNT_HI  = 5'd2;
    localparam logic [4:0] POS_CNT_LO  = 5'd3;
    localparam logic [4:0] POS_ADDR_3  = 5'd4;
    localparam logic [4:0] POS_ADDR_2  = 5'd5;
    localparam logic [4:0] POS_ADDR_1  = 5'd6;
    localparam logic [4:0] POS_ADDR_0  = 5'd7;
    localparam logic [4:0] POS_DATA_HI = 5'd8;
    localparam logic [4:0] POS_DATA_LO = 5'd9;
    localparam logic [4:0] POS_SUM_HI  = 5'd10;
    localparam logic [4:0] POS_SUM_LO  = 5'd11;
    localparam logic [4:0] POS_NEWLINE = 5'd12;
    localparam logic [4:0] POS_TERM    = 5'd13;
    localparam logic [4:0] POS_FINAL   = 5'd23;

    logic              busy_reg, busy_next;
    logic [4:0]        pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;

    logic              load;
    logic [4:0]        pos;
    logic [4:0]        term_off;
    logic              final_char;
    logic [CHAR_W-1:0] ch;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

    // output register can take a character
    assign load = !out_valid_reg || out_ready;

    // current position, first one follows the header flag
    assign pos      = busy_reg ? pos_reg : (head_cmd.header ? POS_S : POS_DATA_HI);
    assign term_off = pos - POS_TERM;

    assign final_char = (pos == POS_DATA_LO && !head_cmd.rec_end)
                     || (pos == POS_NEWLINE && !head_cmd.image_end)
                     || (pos == POS_FINAL);

    // character select
    always_comb begin
        case (pos)
            POS_S:       ch = CHAR_S;
            POS_ONE:     ch = CHAR_1;
            POS_CNT_HI:  ch = hex_char(head_cmd.count[7:4]);
            POS_CNT_LO:  ch = hex_char(head_cmd.count[3:0]);
            POS_ADDR_3:  ch = hex_char(head_cmd.addr[15:12]);
            POS_ADDR_2:  ch = hex_char(head_cmd.addr[11:8]);
            POS_ADDR_1:  ch = hex_char(head_cmd.addr[7:4]);
            POS_ADDR_0:  ch = hex_char(head_cmd.addr[3:0]);
            POS_DATA_HI: ch = hex_char(head_cmd.data[7:4]);
            POS_DATA_LO: ch = hex_char(head_cmd.data[3:0]);
            POS_SUM_HI:  ch = hex_char(head_cmd.checksum[7:4]);
            POS_SUM_LO:  ch = hex_char(head_cmd.checksum[3:0]);
            POS_NEWLINE: ch = CHAR_LF;
            default:     ch = (pos >= POS_TERM && pos <= POS_FINAL)
                              ? TERM_CHARS[term_off[3:0]] : CHAR_LF;
        endcase
    end

    // sequencer and output register
    always_comb begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        if (load) begin
            out_valid_next = q_stat.not_empty;
            if (q_stat.not_empty) begin
                out_char_next = ch;
                out_last_next = final_char;
                if (final_char) begin
                    pop       = 1'b1;
                    busy_next = 1'b0;
                end else begin
                    busy_next = 1'b1;
                    pos_next  = pos + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_char_reg <= out_char_next;
    end

endmodule

/* rtl/srecord_s1_encoder.sv */
// top level of the motorola s1 record encoder
// Takes one program byte per request on the s_ stream and emits the uppercase ASCII
// text of S1 records on the m_ stream, one character per request, with m_tlast on
// the final character caused by each byte. The front end accepts a byte in every
// cycle while its request queue (QUEUE_DEPTH entries) has room; the sequencer sends
// one character per cycle while a request is queued and m_tready allows. A byte
// yields 2 characters in mid-record, 10 when it opens a record, 3 more when it
// closes one and 11 more for the S9 terminator after the image's last byte
// (2 + 11 / record_length on average). The user must write configuration through
// cfg_wr_en, cfg_index and cfg_wr_data only while idle; the block does not check.
module srecord_s1_encoder #(
    parameter int QUEUE_DEPTH = srec_pkg::QUEUE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [srec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srec_pkg::CFG_W-1:0]     cfg_wr_data,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    // output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // [6:0] character, [7] zero
    output logic                           m_tlast    // last_of_run
);
    import srec_pkg::*;

    srec_cmd_t         push_cmd, head_cmd;
    srec_q_stat_t      q_stat;
    logic              push, pop;
    logic [CHAR_W-1:0] out_char;

    // byte classification and record bookkeeping
    srec_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_data     (s_tdata),
        .in_ready    (s_tready),
        .q_stat      (q_stat),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // request queue
    srec_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    // character sequencer
    srec_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_cmd  (head_cmd),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_char  (out_char),
        .out_last  (m_tlast),
        .out_ready (m_tready)
    );

    assign m_tdata = {1'b0, out_char};

endmodule

/* rtl/srec_checker.sv */
// port-level checks for the s1 record encoder, bound to the top level
module srec_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled output request holds its contents
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output request changed while stalled");

    // no output request right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // characters stay 7-bit ascii
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[7])
        else $error("pad bit set");

    // a run ends on a newline or on an uppercase hex digit
    a_last_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |->
            (m_tdata == 8'h0A) || (m_tdata >= 8'h30 && m_tdata <= 8'h39)
            || (m_tdata >= 8'h41 && m_tdata <= 8'h46))
        else $error("run ends on an unexpected character");

endmodule

bind srecord_s1_encoder srec_checker u_srec_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
